// File: design/mmc_pkg.sv
// Shared types and constants for the magnetometer min/max calibration block.
package mmc_pkg;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_CAL    = 2'd1,
    CMD_LOAD   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  localparam int NumAxes = 3;
  localparam logic signed [15:0] BadRaw  = -16'sd4096;
  localparam logic signed [15:0] InitMin = -16'sd400;
  localparam logic signed [15:0] InitMax = 16'sd400;

  // Request from the front end to one axis lane.
  typedef struct packed {
    logic              start;
    logic              cal;
    logic              raw_ok;
    logic              load;
    logic signed [15:0] raw;
    logic signed [15:0] bmin;
    logic signed [15:0] bmax;
  } lane_req_t;

  // Result of one axis lane.
  typedef struct packed {
    logic signed [31:0] mag;
    logic               cal_err;
  } lane_res_t;

endpackage

// File: design/mmc_div.sv
// Restoring divider, one quotient bit per cycle.
module mmc_div #(
  parameter int NumWidth = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NumWidth-1:0] num_i,
  input  logic [15:0]         den_i,
  output logic                done_o,
  output logic [NumWidth-1:0] quo_o
);
  localparam int CntWidth = $clog2(NumWidth + 1);

  logic [CntWidth-1:0] cnt_q;
  logic                done_q;
  logic [NumWidth-1:0] acc_q;
  logic [15:0]         rem_q;
  logic [15:0]         den_q;
  logic [16:0]         trial;
  logic                fits;

  assign trial = {rem_q, acc_q[NumWidth-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CntWidth'(1));
      if (start_i) begin
        cnt_q <= CntWidth'(NumWidth);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CntWidth'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      // shift one numerator bit into the remainder, subtract when it fits
      if (fits) begin
        rem_q <= 16'(trial - {1'b0, den_q});
        acc_q <= {acc_q[NumWidth-2:0], 1'b1};
      end else begin
        rem_q <= trial[15:0];
        acc_q <= {acc_q[NumWidth-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = acc_q;
endmodule

// File: design/mmc_lane.sv
// One axis lane: bounds, scale/offset recompute and calibrated output.
module mmc_lane #(
  parameter int SCALE_FRAC_BITS = 30
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mmc_pkg::lane_req_t req_i,
  input  logic               go_i,
  output logic               done_o,
  output mmc_pkg::lane_res_t res_o
);
  import mmc_pkg::*;

  localparam int NumWidth = SCALE_FRAC_BITS + 2;
  localparam int Sh = SCALE_FRAC_BITS - 16;
  localparam logic [31:0] ScaleOne = (SCALE_FRAC_BITS >= 31) ? 32'h7FFF_FFFF
                                     : 32'(64'd1 << SCALE_FRAC_BITS);
  localparam logic signed [48:0] OffOne = 49'sd1 <<< SCALE_FRAC_BITS;
  localparam logic signed [49:0] Rnd = (50'sd1 <<< Sh) >>> 1;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_WIDEN  = 9'b000000010,
    ST_PREP   = 9'b000000100,
    ST_DIV    = 9'b000001000,
    ST_SAT    = 9'b000010000,
    ST_OFFS   = 9'b000100000,
    ST_COMMIT = 9'b001000000,
    ST_MUL    = 9'b010000000,
    ST_OUT    = 9'b100000000
  } state_e;

  state_e              state_q;
  logic signed [15:0]  held_q, min_q, max_q;
  logic signed [31:0]  scale_q, s_q;
  logic signed [47:0]  off_q, prod1_q, prod2_q;
  logic                cal_q, err_q, neg_q, zero_q;

  logic signed [16:0]  diff, dabs;
  logic [15:0]         den;
  logic [NumWidth-1:0] num, quo;
  logic                div_done;
  logic [63:0]         q64;
  logic signed [31:0]  s_d;
  logic signed [48:0]  off_d;
  logic signed [49:0]  sum, shifted;

  assign diff = {max_q[15], max_q} - {min_q[15], min_q};
  assign dabs = diff[16] ? -diff : diff;
  assign den  = dabs[15:0];
  assign num  = (NumWidth'(1) << (SCALE_FRAC_BITS + 1)) + NumWidth'(den >> 1);

  mmc_div #(.NumWidth(NumWidth)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(state_q == ST_PREP),
    .num_i  (num),
    .den_i  (den),
    .done_o (div_done),
    .quo_o  (quo)
  );

  // saturate the rounded quotient and apply the sign of the range
  always_comb begin
    q64 = 64'(quo);
    if (!neg_q) begin
      s_d = (q64 > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : signed'(q64[31:0]);
    end else begin
      s_d = (q64 > 64'h8000_0000) ? 32'sh8000_0000 : signed'(-q64[31:0]);
    end
  end

  assign off_d = OffOne - {prod1_q[47], prod1_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      held_q  <= '0;
      min_q   <= InitMin;
      max_q   <= InitMax;
      scale_q <= signed'(ScaleOne);
      off_q   <= '0;
      cal_q   <= 1'b0;
      err_q   <= 1'b0;
      neg_q   <= 1'b0;
      zero_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (req_i.load) begin
            min_q <= req_i.bmin;
            max_q <= req_i.bmax;
          end else if (req_i.start) begin
            if (req_i.raw_ok) held_q <= req_i.raw;
            cal_q   <= req_i.cal;
            err_q   <= 1'b0;
            state_q <= req_i.cal ? ST_WIDEN : ST_MUL;
          end
        end
        ST_WIDEN: begin
          if (held_q < min_q) min_q <= held_q;
          if (held_q > max_q) max_q <= held_q;
          state_q <= ST_PREP;
        end
        ST_PREP: begin
          neg_q   <= diff[16];
          zero_q  <= (diff == '0);
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) state_q <= ST_SAT;
        end
        ST_SAT:  state_q <= ST_OFFS;
        ST_OFFS: state_q <= ST_COMMIT;
        ST_COMMIT: begin
          // zero range: keep the old scale and offset
          if (zero_q) begin
            err_q <= 1'b1;
          end else begin
            scale_q <= s_q;
            off_q   <= off_d[47:0];
          end
          state_q <= ST_MUL;
        end
        ST_MUL: state_q <= ST_OUT;
        ST_OUT: begin
          if (go_i) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SAT)  s_q     <= s_d;
    if (state_q == ST_OFFS) prod1_q <= 48'(max_q) * 48'(s_q);
    if (state_q == ST_MUL)  prod2_q <= 48'(scale_q) * 48'(held_q);
  end

  // round half up, then clamp to Q15.16
  always_comb begin
    sum     = 50'(prod2_q) + 50'(off_q) + Rnd;
    shifted = sum >>> Sh;
    res_o.cal_err = cal_q & err_q;
    if (shifted > 50'sh7FFF_FFFF) begin
      res_o.mag = 32'sh7FFF_FFFF;
    end else if (shifted < -50'sh8000_0000) begin
      res_o.mag = 32'sh8000_0000;
    end else begin
      res_o.mag = shifted[31:0];
    end
  end

  assign done_o = (state_q == ST_OUT) && go_i;
endmodule

// File: design/mmc_merge.sv
// Merge stage: combine lane results and error flags into the output word.
module mmc_merge (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               done_i,
  input  mmc_pkg::lane_res_t res_x_i,
  input  mmc_pkg::lane_res_t res_y_i,
  input  mmc_pkg::lane_res_t res_z_i,
  input  logic               meas_err_i,
  output logic               go_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] mag_x_o,
  output logic signed [31:0] mag_y_o,
  output logic signed [31:0] mag_z_o,
  output logic               measurement_error_o,
  output logic               calib_error_o
);
  logic valid_q;

  // lanes may finish only when the output register is free or draining
  assign go_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (done_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_i) begin
      mag_x_o             <= res_x_i.mag;
      mag_y_o             <= res_y_i.mag;
      mag_z_o             <= res_z_i.mag;
      measurement_error_o <= meas_err_i;
      calib_error_o       <= res_x_i.cal_err | res_y_i.cal_err | res_z_i.cal_err;
    end
  end

  assign out_valid_o = valid_q;
endmodule

// File: design/magnetometer_minmax_calibration.sv
// Calibrating words run widen, prep, divide, saturate, offset, commit, multiply and
// output; other samples run multiply and output. Each lane has its own divider, one bit
// per cycle. One sample is in flight; the next is taken once the result reaches the
// output register. Load words set the addressed lane's bounds. Reset is asynchronous,
// active low, and sets bounds to +-400, scale to 1.0, offset and held samples to zero.
module magnetometer_minmax_calibration #(
  parameter int SCALE_FRAC_BITS = 30
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_auto_calibrate_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         cmd_i,
  input  logic [7:0]         x_high_i,
  input  logic [7:0]         x_low_i,
  input  logic [7:0]         z_high_i,
  input  logic [7:0]         z_low_i,
  input  logic [7:0]         y_high_i,
  input  logic [7:0]         y_low_i,
  input  logic [1:0]         axis_i,
  input  logic signed [15:0] bound_min_i,
  input  logic signed [15:0] bound_max_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] mag_x_o,
  output logic signed [31:0] mag_y_o,
  output logic signed [31:0] mag_z_o,
  output logic               measurement_error_o,
  output logic               calib_error_o
);
  import mmc_pkg::*;

  logic               auto_q, busy_q, meas_q;
  logic               accept, sample, go;
  logic [NumAxes-1:0] done;
  logic signed [15:0] raw [NumAxes];
  lane_req_t          req [NumAxes];
  lane_res_t          res [NumAxes];
  cmd_e               cmd;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy_q;
  assign accept      = in_valid_i && !busy_q;
  assign cmd         = cmd_e'(cmd_i);
  assign sample      = accept && (cmd == CMD_SAMPLE || cmd == CMD_CAL);

  assign raw[0] = signed'({x_high_i, x_low_i});
  assign raw[1] = signed'({y_high_i, y_low_i});
  assign raw[2] = signed'({z_high_i, z_low_i});

  logic meas_err;
  assign meas_err = (raw[0] == BadRaw) || (raw[1] == BadRaw) || (raw[2] == BadRaw);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_q <= 1'b0;
      busy_q <= 1'b0;
      meas_q <= 1'b0;
    end else begin
      if (cfg_valid_i) auto_q <= cfg_auto_calibrate_i;
      if (sample) begin
        busy_q <= 1'b1;
        meas_q <= meas_err;
      end else if (done[0]) begin
        busy_q <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < NumAxes; i++) begin : g_lane
    always_comb begin
      req[i].start  = sample;
      req[i].cal    = auto_q || (cmd == CMD_CAL);
      req[i].raw_ok = !meas_err;
      req[i].load   = accept && (cmd == CMD_LOAD) && (axis_i == 2'(i));
      req[i].raw    = raw[i];
      req[i].bmin   = bound_min_i;
      req[i].bmax   = bound_max_i;
    end

    mmc_lane #(.SCALE_FRAC_BITS(SCALE_FRAC_BITS)) u_lane (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .req_i (req[i]),
      .go_i  (go),
      .done_o(done[i]),
      .res_o (res[i])
    );
  end

  // lanes run in lockstep, so their done strobes coincide; the merge takes all three ANDed
  mmc_merge u_merge (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .done_i             (done[0] & done[1] & done[2]),
    .res_x_i            (res[0]),
    .res_y_i            (res[1]),
    .res_z_i            (res[2]),
    .meas_err_i         (meas_q),
    .go_o               (go),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .mag_x_o            (mag_x_o),
    .mag_y_o            (mag_y_o),
    .mag_z_o            (mag_z_o),
    .measurement_error_o(measurement_error_o),
    .calib_error_o      (calib_error_o)
  );
endmodule

// File: tb/magnetometer_minmax_calibration_tb.sv
// Self-checking testbench for the magnetometer min/max calibration block.
module magnetometer_minmax_calibration_tb;
  import mmc_pkg::*;

  localparam int FracBits = 30;
  localparam longint CycleLimit = 2000000;

  typedef struct packed {
    logic signed [31:0] mag_x;
    logic signed [31:0] mag_y;
    logic signed [31:0] mag_z;
    logic               meas_err;
    logic               cal_err;
  } field_word_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [7:0]         xh, xl, zh, zl, yh, yl;
    logic [1:0]         axis;
    logic signed [15:0] bmin, bmax;
  } sample_word_t;

  logic clk, rst_n;
  logic cfg_valid, cfg_ready, cfg_auto;
  logic in_valid, in_stall, out_valid, out_stall;
  sample_word_t drv;
  logic signed [31:0] mag_x, mag_y, mag_z;
  logic meas_err, cal_err;

  int errors;
  longint cycles;
  int send_idle_pct, recv_idle_pct;

  function automatic void report(input string what);
    $display("mismatch: %s", what);
    errors++;
  endfunction

  class field_scoreboard;
    bit auto_cal;
    logic signed [31:0] held[3];
    logic signed [31:0] lo[3], hi[3];
    longint scale[3], offset[3];
    field_word_t pending[$];

    function void clear();
      auto_cal = 0;
      for (int i = 0; i < 3; i++) begin
        held[i] = 0; lo[i] = -400; hi[i] = 400;
        scale[i] = longint'(1) << FracBits; offset[i] = 0;
      end
    endfunction

    function bit widen(int i);
      longint diff, d, q;
      if (held[i] < lo[i]) lo[i] = held[i];
      if (held[i] > hi[i]) hi[i] = held[i];
      diff = hi[i] - lo[i];
      if (diff == 0) return 1;
      d = diff < 0 ? -diff : diff;
      q = ((longint'(2) << FracBits) + d / 2) / d;
      if (diff > 0) scale[i] = q > 64'h7FFFFFFF ? 64'h7FFFFFFF : q;
      else scale[i] = q > 64'h80000000 ? -64'sh80000000 : -q;
      offset[i] = (longint'(1) << FracBits) - longint'(hi[i]) * scale[i];
      return 0;
    endfunction

    function logic signed [31:0] field_of(int i);
      longint v, w;
      v = scale[i] * longint'(held[i]) + offset[i];
      w = (v + (longint'(1) << (FracBits - 17))) >>> (FracBits - 16);
      if (w > 64'sh7FFFFFFF) w = 64'sh7FFFFFFF;
      if (w < -64'sh80000000) w = -64'sh80000000;
      return w[31:0];
    endfunction

    function void note_word(sample_word_t s);
      logic signed [15:0] r[3];
      field_word_t e;
      bit ce;
      ce = 0;
      if (s.cmd == CMD_LOAD) begin
        if (s.axis != 2'd3) begin lo[s.axis] = s.bmin; hi[s.axis] = s.bmax; end
        return;
      end
      if (s.cmd == CMD_NONE) return;
      r[0] = {s.xh, s.xl}; r[1] = {s.yh, s.yl}; r[2] = {s.zh, s.zl};
      e.meas_err = (r[0] == BadRaw) || (r[1] == BadRaw) || (r[2] == BadRaw);
      if (!e.meas_err) for (int i = 0; i < 3; i++) held[i] = r[i];
      if (auto_cal || s.cmd == CMD_CAL)
        for (int i = 0; i < 3; i++) if (widen(i)) ce = 1;
      e.cal_err = ce;
      e.mag_x = field_of(0); e.mag_y = field_of(1); e.mag_z = field_of(2);
      pending.push_back(e);
    endfunction

    function void check_word(field_word_t g);
      field_word_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result x=%0d", g.mag_x));
        return;
      end
      e = pending.pop_front();
      if (g.mag_x !== e.mag_x) report($sformatf("mag_x %0d exp %0d", g.mag_x, e.mag_x));
      if (g.mag_y !== e.mag_y) report($sformatf("mag_y %0d exp %0d", g.mag_y, e.mag_y));
      if (g.mag_z !== e.mag_z) report($sformatf("mag_z %0d exp %0d", g.mag_z, e.mag_z));
      if (g.meas_err !== e.meas_err) report("measurement_error");
      if (g.cal_err !== e.cal_err) report("calib_error");
    endfunction
  endclass

  field_scoreboard sb;

  magnetometer_minmax_calibration #(.SCALE_FRAC_BITS(FracBits)) dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_auto_calibrate_i(cfg_auto),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .cmd_i(drv.cmd), .x_high_i(drv.xh), .x_low_i(drv.xl), .z_high_i(drv.zh),
    .z_low_i(drv.zl), .y_high_i(drv.yh), .y_low_i(drv.yl), .axis_i(drv.axis),
    .bound_min_i(drv.bmin), .bound_max_i(drv.bmax),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .mag_x_o(mag_x), .mag_y_o(mag_y), .mag_z_o(mag_z),
    .measurement_error_o(meas_err), .calib_error_o(cal_err)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Receiver: random stall, check on accept.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_word('{mag_x, mag_y, mag_z, meas_err, cal_err});
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_cfg(input bit v);
    cfg_valid <= 1; cfg_auto <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.auto_cal = v;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (FracBits + 20) @(posedge clk);
  endtask

  // hold valid after an accepted word; drop it only while idling
  task automatic send_word(input sample_word_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; drv <= s;
    do @(posedge clk); while (in_stall);
    sb.note_word(s);
  endtask

  function automatic sample_word_t make_sample(logic [1:0] c, logic signed [15:0] x,
                                               logic signed [15:0] y, logic signed [15:0] z);
    sample_word_t s;
    s = '0;
    s.cmd = c; {s.xh, s.xl} = x; {s.yh, s.yl} = y; {s.zh, s.zl} = z;
    return s;
  endfunction

  function automatic sample_word_t make_load(logic [1:0] ax, logic signed [15:0] mn,
                                             logic signed [15:0] mx);
    sample_word_t s;
    s = sample_word_t'(84'({$urandom, $urandom, $urandom}));
    s.cmd = CMD_LOAD; s.axis = ax; s.bmin = mn; s.bmax = mx;
    return s;
  endfunction

  function automatic logic signed [15:0] rand_raw();
    case ($urandom_range(9))
      0: return BadRaw;
      1: return $urandom_range(1) ? 16'sh7FFF : -16'sh8000;
      2, 3: return 16'($urandom);
      default: return 16'($signed($urandom_range(1600)) - 800);
    endcase
  endfunction

  task automatic random_word();
    sample_word_t s;
    int k;
    k = $urandom_range(99);
    if (k < 10) s = make_load(2'($urandom_range(3)), rand_raw(), rand_raw());
    else if (k < 13) begin
      s = sample_word_t'(84'({$urandom, $urandom, $urandom}));
      s.cmd = CMD_NONE;
    end else begin
      s = make_sample($urandom_range(1) ? CMD_SAMPLE : CMD_CAL,
                      rand_raw(), rand_raw(), rand_raw());
      s.axis = 2'($urandom); s.bmin = 16'($urandom); s.bmax = 16'($urandom);
    end
    send_word(s);
  endtask

  initial begin
    sb = new();
    sb.clear();
    errors = 0; cycles = 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    rst_n = 0; cfg_valid = 0; cfg_auto = 0; in_valid = 0; out_stall = 0; drv = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: extremes, all commands, error and corner cases.
    send_word(make_sample(CMD_SAMPLE, 16'sd0, 16'sd0, 16'sd0));
    send_word(make_sample(CMD_SAMPLE, 16'sh7FFF, -16'sh8000, 16'sd400));
    send_word(make_sample(CMD_SAMPLE, BadRaw, 16'sd5, 16'sd6));
    send_word(make_sample(CMD_CAL, 16'sd100, -16'sd100, 16'sd50));
    send_word(make_sample(CMD_CAL, 16'sh7FFF, -16'sh8000, BadRaw));
    send_word(make_load(2'd0, 16'sd7, 16'sd7));
    send_word(make_sample(CMD_CAL, 16'sd7, 16'sd1, 16'sd2));
    send_word(make_load(2'd1, 16'sd300, -16'sd300));
    send_word(make_sample(CMD_CAL, 16'sd0, 16'sd0, 16'sd0));
    send_word(make_load(2'd2, -16'sh8000, 16'sh7FFF));
    send_word(make_load(2'd0, 16'sd0, 16'sd1));
    send_word(make_sample(CMD_CAL, 16'sd1, 16'sd10, -16'sh8000));
    send_word(make_load(2'd3, 16'sd5, 16'sd5));
    send_word(make_sample(CMD_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_word(make_load(2'd1, 16'sd3, 16'sd3));
    send_word(make_sample(CMD_SAMPLE, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    drain();
    write_cfg(1);
    send_word(make_sample(CMD_SAMPLE, 16'sd3, 16'sd3, 16'sd3));
    send_word(make_sample(CMD_SAMPLE, -16'sd20000, 16'sd20000, 16'sd1));
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 80 : 0;
      recv_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 34 : 0;
      for (int n = 0; n < 350; n++) random_word();
      drain();
      write_cfg(phase != 0);
    end
    drain();

    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: filelist.f
design/mmc_pkg.sv
design/mmc_div.sv
design/mmc_lane.sv
design/mmc_merge.sv
design/magnetometer_minmax_calibration.sv
tb/magnetometer_minmax_calibration_tb.sv
